>>> hw/rtl/lro_pkg.sv
// Package for the linear reservoir outflow core.
// Holds fixed widths, rounding constants and the decay factor table.
// No dependencies.
`timescale 1ns / 1ps

package lro_pkg;

    // Storage factor K, unsigned Q8.8
    localparam int K_W = 16;
    // Reciprocal 1/K in Q.12, only 16 bits used once short K is split off
    localparam int R_W = 16;
    // Partial remainder of the reciprocal division
    localparam int REM_W = 17;
    // Decay accumulator in Q0.24, holds 1.0
    localparam int ACC_W = 25;
    // Recession factor e in Q0.16, holds 1.0
    localparam int E_W = 17;
    // e in Q0.24 as a multiplier operand
    localparam int WMUL_W = 25;
    // K*(1-e) in Q.24
    localparam int KG_W = 33;
    // Volumes are split into two halves for the multipliers
    localparam int HALF_W = 24;
    localparam int EXT_W = 2 * HALF_W;
    // Storage sum before clamping
    localparam int SUM_W = 58;

    // K at or below this value gives 1/K >= 16, where e is taken as zero
    localparam logic [K_W-1:0] SHORT_K_MAX = 16'd16;
    // Remainder left after the five top quotient bits, which are zero for long K
    localparam logic [REM_W-1:0] DIV_INIT = 17'd16;
    localparam logic [ACC_W-1:0] ACC_ONE = 25'h100_0000;
    localparam logic [E_W-1:0] E_ONE = 17'h1_0000;
    localparam logic [SUM_W-1:0] Q24_HALF = 58'h80_0000;

    // round(2^24 * exp(-2^(b-12))) for b = 0..15
    localparam logic [23:0] DECAY_TAB [0:15] = '{
        24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
        24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
        24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
        24'd6171993,  24'd2270549,  24'd307285,   24'd5628
    };

endpackage

>>> hw/rtl/lake_linear_reservoir_outflow_core.sv
// Top level of the linear reservoir outflow core.
// Depends on lro_pkg, lro_front, lro_queue and lro_back.
`timescale 1ns / 1ps

// Linear reservoir routing for one cell per word: from stored volume, inflow,
// capacity and K it gives the new storage, clamped to zero..capacity and to
// water plus inflow, and the mass-balanced outflow. One word is taken and one
// result given per clock while the output side is ready. An accepted word
// passes through the four-entry input queue, the bit-per-stage reciprocal
// 1/K, the decay multiplier chain for exp(-1/K) and the storage arithmetic,
// whose last stage loads the output register. A stalled output freezes the
// pipe; the input queue keeps taking words until it is full.
module lake_linear_reservoir_outflow_core
    import lro_pkg::*;
#(
    parameter int VOLUME_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VOLUME_WIDTH-1:0] water_volume,
    input  logic [VOLUME_WIDTH-1:0] inflow_volume,
    input  logic [VOLUME_WIDTH-1:0] capacity_volume,
    input  logic [K_W-1:0]          store_factor,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [VOLUME_WIDTH:0]   outflow_volume,
    output logic [VOLUME_WIDTH-1:0] new_storage
);

    localparam int VW = VOLUME_WIDTH;
    localparam int QW = 3 * VW + K_W + 1;

    logic          q_full, q_push, q_pop, q_not_empty;
    logic          short_k;
    logic [QW-1:0] q_in, q_head;

    // Classify incoming words
    lro_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .store_factor (store_factor),
        .q_full       (q_full),
        .q_push       (q_push),
        .short_k      (short_k)
    );

    assign q_in = {water_volume, inflow_volume, capacity_volume, store_factor, short_k};

    // Decouple front from back
    lro_queue #(.W(QW), .DEPTH(4)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    // Compute storage and outflow
    lro_back #(.VW(VW)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_pop          (q_pop),
        .water          (q_head[QW-1 -: VW]),
        .inflow         (q_head[QW-VW-1 -: VW]),
        .cap            (q_head[K_W+VW : K_W+1]),
        .k              (q_head[K_W:1]),
        .short_k        (q_head[0]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outflow_volume (outflow_volume),
        .new_storage    (new_storage)
    );

endmodule

>>> hw/rtl/lro_front.sv
// Front end of the reservoir core: takes input words and classifies them.
// Depends on lro_pkg.
`timescale 1ns / 1ps

module lro_front
    import lro_pkg::*;
(
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [K_W-1:0] store_factor,
    input  logic           q_full,
    output logic           q_push,
    output logic           short_k
);

    // Take a word whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Flag K short enough for e to vanish, zero K included
    assign short_k = (store_factor <= SHORT_K_MAX);

endmodule

>>> hw/rtl/lro_queue.sv
// Small register FIFO between the front and back ends.
// Depends on lro_pkg only for the common import style.
`timescale 1ns / 1ps

module lro_queue
    import lro_pkg::*;
#(
    parameter int W     = 113,
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head_data
);

    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && not_empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && not_empty)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && not_empty)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue fill level above depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

>>> hw/rtl/lro_back.sv
// Back end of the reservoir core: reciprocal, decay chain, storage and outflow.
// Depends on lro_pkg.
`timescale 1ns / 1ps

module lro_back
    import lro_pkg::*;
#(
    parameter int VW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  logic [VW-1:0] water,
    input  logic [VW-1:0] inflow,
    input  logic [VW-1:0] cap,
    input  logic [K_W-1:0] k,
    input  logic          short_k,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [VW:0]   outflow_volume,
    output logic [VW-1:0] new_storage
);

    localparam int NS = 2 * R_W;

    logic adv;

    // Stage arrays: index 0 is the queue head, index i+1 the output of stage i
    logic              v_s     [0:NS];
    logic [VW-1:0]     water_s [0:NS];
    logic [VW-1:0]     inflow_s[0:NS];
    logic [VW-1:0]     cap_s   [0:NS];
    logic [K_W-1:0]    k_s     [0:NS];
    logic              short_s [0:NS];
    logic [REM_W-1:0]  rem_s   [0:NS];
    logic [R_W-1:0]    r_s     [0:NS];
    logic [ACC_W-1:0]  acc_s   [0:NS];

    logic              v_e1_reg, v_e2_reg, v_m_reg, v_a1_reg, v_a2_reg, v_c_reg;
    logic              out_valid_reg;
    logic [VW-1:0]     water_e1_reg, inflow_e1_reg, cap_e1_reg;
    logic [VW-1:0]     water_e2_reg, inflow_e2_reg, cap_e2_reg;
    logic [K_W-1:0]    k_e1_reg;
    logic [E_W-1:0]    e16_reg, g_reg;
    logic [WMUL_W-1:0] wmul_reg;
    logic [KG_W-1:0]   kg_reg;
    logic [EXT_W-1:0]  w_ext, i_ext;
    logic [2*HALF_W:0] p_wl_reg, p_wh_reg;
    logic [HALF_W+KG_W-1:0] p_il_reg, p_ih_reg;
    logic [VW:0]       total_m_reg, total_a1_reg, total_a2_reg, total_c_reg;
    logic [VW-1:0]     cap_m_reg, cap_a1_reg, cap_a2_reg;
    logic [SUM_W-1:0]  low_reg, hi_reg, s_reg;
    logic [SUM_W-1:0]  clip_cap, clip_tot;
    logic [VW-1:0]     stor_c_reg;
    logic [VW:0]       outflow_reg;
    logic [VW-1:0]     storage_reg;

    // Advance the whole pipe unless a finished word is stuck at the output
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    assign v_s[0]      = q_valid;
    assign water_s[0]  = water;
    assign inflow_s[0] = inflow;
    assign cap_s[0]    = cap;
    assign k_s[0]      = k;
    assign short_s[0]  = short_k;
    assign rem_s[0]    = DIV_INIT;
    assign r_s[0]      = '0;
    assign acc_s[0]    = ACC_ONE;

    // Reciprocal stages, one quotient bit each (MSB first), then decay stages
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic             ge;
        logic [ACC_W+23:0] prod;

        assign rem_sh = {rem_s[i][REM_W-2:0], 1'b0};
        assign ge     = (rem_sh >= REM_W'(k_s[i]));
        assign prod   = ((ACC_W+24)'(acc_s[i]) * (ACC_W+24)'(DECAY_TAB[(i >= R_W) ? i - R_W : 0]))
                        + (ACC_W+24)'(Q24_HALF);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_s[i+1] <= 1'b0;
            else if (adv)
                v_s[i+1] <= v_s[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                water_s[i+1]  <= water_s[i];
                inflow_s[i+1] <= inflow_s[i];
                cap_s[i+1]    <= cap_s[i];
                k_s[i+1]      <= k_s[i];
                short_s[i+1]  <= short_s[i];
                if (i < R_W)
                begin
                    rem_s[i+1] <= ge ? rem_sh - REM_W'(k_s[i]) : rem_sh;
                    r_s[i+1]   <= r_s[i] | (R_W'(ge) << (R_W - 1 - i));
                    acc_s[i+1] <= acc_s[i];
                end
                else
                begin
                    rem_s[i+1] <= rem_s[i];
                    r_s[i+1]   <= r_s[i];
                    if (r_s[i][(i >= R_W) ? i - R_W : 0])
                        acc_s[i+1] <= prod[ACC_W+23:24];
                    else
                        acc_s[i+1] <= acc_s[i];
                end
            end
        end
    end

    assign w_ext = EXT_W'(water_e2_reg);
    assign i_ext = EXT_W'(inflow_e2_reg);

    // Clamp storage to capacity, then to water plus inflow
    assign clip_cap = (s_reg > SUM_W'(cap_a2_reg)) ? SUM_W'(cap_a2_reg) : s_reg;
    assign clip_tot = (clip_cap > SUM_W'(total_a2_reg)) ? SUM_W'(total_a2_reg) : clip_cap;

    // Valid bits of the arithmetic tail
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e1_reg      <= 1'b0;
            v_e2_reg      <= 1'b0;
            v_m_reg       <= 1'b0;
            v_a1_reg      <= 1'b0;
            v_a2_reg      <= 1'b0;
            v_c_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_e1_reg      <= v_s[NS];
            v_e2_reg      <= v_e1_reg;
            v_m_reg       <= v_e2_reg;
            v_a1_reg      <= v_m_reg;
            v_a2_reg      <= v_a1_reg;
            v_c_reg       <= v_a2_reg;
            out_valid_reg <= v_c_reg;
        end
    end

    // Arithmetic tail payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // round e to Q0.16, force zero for short K
            e16_reg       <= short_s[NS] ? '0
                             : E_W'(((ACC_W+1)'(acc_s[NS]) + (ACC_W+1)'(128)) >> 8);
            g_reg         <= short_s[NS] ? E_ONE
                             : E_ONE - E_W'(((ACC_W+1)'(acc_s[NS]) + (ACC_W+1)'(128)) >> 8);
            k_e1_reg      <= k_s[NS];
            water_e1_reg  <= water_s[NS];
            inflow_e1_reg <= inflow_s[NS];
            cap_e1_reg    <= cap_s[NS];

            // K*(1-e) and e in Q0.24
            kg_reg        <= KG_W'(k_e1_reg) * KG_W'(g_reg);
            wmul_reg      <= {e16_reg, 8'b0};
            water_e2_reg  <= water_e1_reg;
            inflow_e2_reg <= inflow_e1_reg;
            cap_e2_reg    <= cap_e1_reg;

            // partial products over volume halves
            p_wl_reg    <= (2*HALF_W+1)'(w_ext[HALF_W-1:0]) * (2*HALF_W+1)'(wmul_reg);
            p_wh_reg    <= (2*HALF_W+1)'(w_ext[EXT_W-1:HALF_W]) * (2*HALF_W+1)'(wmul_reg);
            p_il_reg    <= (HALF_W+KG_W)'(i_ext[HALF_W-1:0]) * (HALF_W+KG_W)'(kg_reg);
            p_ih_reg    <= (HALF_W+KG_W)'(i_ext[EXT_W-1:HALF_W]) * (HALF_W+KG_W)'(kg_reg);
            total_m_reg <= (VW+1)'(water_e2_reg) + (VW+1)'(inflow_e2_reg);
            cap_m_reg   <= cap_e2_reg;

            // sum the halves separately
            low_reg      <= SUM_W'(p_wl_reg) + SUM_W'(p_il_reg) + Q24_HALF;
            hi_reg       <= SUM_W'(p_wh_reg) + SUM_W'(p_ih_reg);
            total_a1_reg <= total_m_reg;
            cap_a1_reg   <= cap_m_reg;

            // combine into the unclamped storage in Q.0, whole volume units
            s_reg        <= hi_reg + (low_reg >> HALF_W);
            total_a2_reg <= total_a1_reg;
            cap_a2_reg   <= cap_a1_reg;

            stor_c_reg  <= clip_tot[VW-1:0];
            total_c_reg <= total_a2_reg;

            // mass-balanced outflow
            outflow_reg <= total_c_reg - (VW+1)'(stor_c_reg);
            storage_reg <= stor_c_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign outflow_volume = outflow_reg;
    assign new_storage    = storage_reg;

    a_short_zero_e: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_s[NS] && short_s[NS]) |=> (e16_reg == '0))
        else $error("short K did not give zero recession factor");
    a_mass_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_c_reg) |=> ((VW+1)'(outflow_reg) + (VW+1)'(storage_reg)
                              == $past(total_c_reg)))
        else $error("outflow plus storage differs from water plus inflow");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(storage_reg)))
        else $error("result changed while stalled");

endmodule

>>> tb/tb.sv
// Testbench for the linear reservoir outflow core.
// Depends on lro_pkg and lake_linear_reservoir_outflow_core; self-checking.
`timescale 1ns / 1ps

module tb
    import lro_pkg::*;
();

    localparam int VW = 32;
    localparam int WATCHDOG_MAX = 20000;
    localparam int N_RANDOM = 1700;
    localparam int N_DIRECTED = 20;

    // Decay factors round(2^24 * exp(-2^(b-12))) for b = 0..15
    localparam logic [23:0] DECAY_Q24 [0:15] = '{
        24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
        24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
        24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
        24'd6171993,  24'd2270549,  24'd307285,   24'd5628
    };

    typedef struct packed {
        logic [VW-1:0]  water;
        logic [VW-1:0]  inflow;
        logic [VW-1:0]  cap;
        logic [K_W-1:0] k;
    } cell_t;

    typedef struct packed {
        logic [VW:0]   outflow;
        logic [VW-1:0] storage;
    } balance_t;

    typedef struct packed {
        cell_t    stim;
        logic     known;
        balance_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [VW-1:0] water_volume;
    logic [VW-1:0] inflow_volume;
    logic [VW-1:0] capacity_volume;
    logic [K_W-1:0] store_factor;
    logic out_valid;
    logic out_ready;
    logic [VW:0] outflow_volume;
    logic [VW-1:0] new_storage;

    balance_t balance_q[$];
    int errors;
    int table_errors;
    int n_checked;
    int idle_cycles;
    bit quiet_out;
    bit src_done;

    lake_linear_reservoir_outflow_core #(.VOLUME_WIDTH(VW)) dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .water_volume(water_volume), .inflow_volume(inflow_volume),
        .capacity_volume(capacity_volume), .store_factor(store_factor),
        .out_valid(out_valid), .out_ready(out_ready),
        .outflow_volume(outflow_volume), .new_storage(new_storage)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Recession factor exp(-1/K) in Q0.16
    function automatic logic [16:0] recession(input logic [K_W-1:0] k_in);
        logic [20:0] kk;
        logic [20:0] r;
        logic [63:0] acc;
        kk = (k_in == '0) ? 21'd1 : {5'd0, k_in};
        r = 21'h10_0000 / kk;
        if (r >= 21'd65536)
            return '0;
        acc = 64'h100_0000;
        for (int b = 0; b < 16; b++)
            if (r[b])
                acc = (acc * DECAY_Q24[b] + 64'h80_0000) >> 24;
        return 17'((acc + 64'd128) >> 8);
    endfunction

    // Route one cell through the reservoir: new storage and outflow
    function automatic balance_t route_cell(input cell_t c);
        logic [127:0] e16;
        logic [127:0] kg;
        logic [127:0] s;
        logic [127:0] total;
        balance_t res;
        e16 = recession(c.k);
        kg = c.k * (128'd65536 - e16);
        s = ({96'd0, c.water} * (e16 << 8) + {96'd0, c.inflow} * kg
             + 128'h80_0000) >> 24;
        total = c.water + c.inflow;
        if (s > c.cap)
            s = c.cap;
        if (s > total)
            s = total;
        res.outflow = (VW + 1)'(total - s);
        res.storage = VW'(s);
        return res;
    endfunction

    function automatic logic [31:0] rand_vol();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 4096);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [K_W-1:0] rand_k();
        case ($urandom_range(0, 4))
            0: return K_W'($urandom_range(0, 32));
            1: return K_W'($urandom_range(200, 2000));
            default: return K_W'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_cell(input cell_t c);
        while ($urandom_range(0, 99) < 8 && !quiet_out)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        water_volume <= c.water;
        inflow_volume <= c.inflow;
        capacity_volume <= c.cap;
        store_factor <= c.k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        balance_q.push_back(route_cell(c));
    endtask

    // Stimulus: directed table, then random cells
    initial
    begin
        row_t rows [N_DIRECTED];
        cell_t c;
        balance_t exp_res;
        rst_n = 1'b0;
        in_valid = 1'b0;
        water_volume = '0;
        inflow_volume = '0;
        capacity_volume = '0;
        store_factor = '0;
        table_errors = 0;
        quiet_out = 1'b0;
        src_done = 1'b0;

        // Zero volumes, all-ones volumes, zero K, short K, max K, clamp cases
        rows[0]  = '{'{32'd0, 32'd0, 32'd0, 16'd0}, 1'b1, '{33'd0, 32'd0}};
        rows[1]  = '{'{'1, '1, '1, 16'd0}, 1'b1, '{33'h1_FFFF_FFFE, 32'd0}};
        rows[2]  = '{'{32'd1000, 32'd500, '1, 16'd16}, 1'b1, '{33'd1469, 32'd31}};
        rows[3]  = '{'{'1, 0, 0, 16'hFFFF}, 1'b1, '{33'h0_FFFF_FFFF, 32'd0}};
        rows[4]  = '{'{0, '1, 0, 16'd256}, 1'b1, '{33'h0_FFFF_FFFF, 32'd0}};
        rows[5]  = '{'{'1, '1, '1, 16'hFFFF}, 1'b0, '0};
        rows[6]  = '{'{0, 32'd256, '1, 16'd1}, 1'b0, '0};
        rows[7]  = '{'{32'd256, 0, '1, 16'd17}, 1'b0, '0};
        rows[8]  = '{'{32'h1234_5678, 32'h0FED_CBA9, '1, 16'd256}, 1'b0, '0};
        rows[9]  = '{'{32'h8000_0000, 32'h8000_0000, 32'h4000_0000, 16'd512}, 1'b0, '0};
        rows[10] = '{'{32'hAAAA_AAAA, 32'h5555_5555, '1, 16'hAAAA}, 1'b0, '0};
        rows[11] = '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 16'h5555}, 1'b0, '0};
        rows[12] = '{'{0, '1, '1, 16'hFFFF}, 1'b0, '0};
        rows[13] = '{'{0, '1, '1, 16'd32768}, 1'b0, '0};
        rows[14] = '{'{'1, 0, '1, 16'd65}, 1'b0, '0};
        rows[15] = '{'{32'd100, 32'd100, 32'd1, 16'd300}, 1'b0, '0};
        rows[16] = '{'{32'd1, 32'd1, '1, 16'd16}, 1'b0, '0};
        rows[17] = '{'{32'd1, 32'd1, '1, 16'd18}, 1'b0, '0};
        rows[18] = '{'{32'hFFFF_0000, 32'h0000_FFFF, '1, 16'd128}, 1'b0, '0};
        rows[19] = '{'{32'h0100_0000, 32'h00FF_FFFF, '1, 16'd4096}, 1'b0, '0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; typed-in results must match the predictor too
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (rows[i].known)
            begin
                exp_res = route_cell(rows[i].stim);
                if (exp_res !== rows[i].res)
                begin
                    $display("%0t table row %0d: expected %h actual %h",
                             $time, i, rows[i].res, exp_res);
                    table_errors++;
                end
            end
            send_cell(rows[i].stim);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Drain the pipe once, midway
            if (i == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (balance_q.size() != 0)
                    @(posedge clk);
            end
            quiet_out = (i >= 300 && i < 600);
            c.water = rand_vol();
            c.inflow = rand_vol();
            c.cap = ($urandom_range(0, 3) == 0) ? rand_vol() : '1;
            c.k = rand_k();
            send_cell(c);
        end
        in_valid <= 1'b0;
        quiet_out = 1'b0;
        src_done = 1'b1;
    end

    // Output side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        balance_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= quiet_out || ($urandom_range(0, 99) >= 8);
            if (out_valid && out_ready)
            begin
                if (balance_q.size() == 0)
                begin
                    $display("%0t unexpected word: outflow %h storage %h",
                             $time, outflow_volume, new_storage);
                    errors++;
                end
                else
                begin
                    want = balance_q.pop_front();
                    n_checked++;
                    if (outflow_volume !== want.outflow)
                    begin
                        $display("%0t outflow_volume: expected %h actual %h",
                                 $time, want.outflow, outflow_volume);
                        errors++;
                    end
                    if (new_storage !== want.storage)
                    begin
                        $display("%0t new_storage: expected %h actual %h",
                                 $time, want.storage, new_storage);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End of run
    initial
    begin
        @(posedge rst_n);
        while (!(src_done && balance_q.size() == 0) && idle_cycles < WATCHDOG_MAX)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog expired with %0d words outstanding", balance_q.size());
            $display("FAILURE");
            $finish;
        end
        repeat (100) @(posedge clk);
        $display("Ran %0d table rows and %0d random cells; %0d results checked.",
                 N_DIRECTED, N_RANDOM, n_checked);
        if (errors == 0 && table_errors == 0 && balance_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lro_pkg.sv
hw/rtl/lro_front.sv
hw/rtl/lro_queue.sv
hw/rtl/lro_back.sv
hw/rtl/lake_linear_reservoir_outflow_core.sv
tb/tb.sv
